// File: src/sll_pkg.sv
// Shared types, constants and helpers for the static linked list engine.
// Used by the RAM-backed datapath, the controller, the top level and the checker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W = 6;
  localparam int LEN_W = 6;
  localparam int VAL_W = 32;

  localparam logic [SLOT_W-1:0] FREE_HEAD = '0;
  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);
  localparam logic [LEN_W-1:0] COUNT_MAX = LEN_W'(SLOTS - 2);

  typedef enum logic {
    FN_INSERT   = 1'b0,
    FN_TRAVERSE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic                    func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_FRESH,
    S_INS_UNLINK,
    S_INS_WALK,
    S_INS_SPLICE,
    S_TRV_FIRST,
    S_TRV_EMIT,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RA_FREE_HEAD,
    RA_LIST_HEAD,
    RA_RDATA
  } ra_sel_t;

  typedef enum logic [1:0] {
    WA_FREE_HEAD,
    WA_FRESH,
    WA_K
  } wa_sel_t;

  typedef enum logic {
    WD_RDATA,
    WD_FRESH
  } wd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    link_re;
    ra_sel_t link_ra;
    logic    link_we;
    wa_sel_t link_wa;
    wd_sel_t link_wd;
    logic    data_re;
    logic    data_we;
    logic    fresh_ld;
    logic    walk_init;
    logic    walk_step;
    logic    count_inc;
    logic    trav_init;
    logic    trav_step;
    logic    resp_ld;
    status_t resp_code;
    logic    out_load;
    logic    out_elem;
  } cmd_t;

  typedef struct packed {
    logic is_traverse;
    logic pos_bad;
    logic count_zero;
    logic full;
    logic walk_go;
    logic link_bad;
    logic trav_last;
    logic out_free;
  } stat_t;

  function automatic logic [SLOT_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] nxt;
    nxt = (slot == HEAD_SLOT) ? '0 : slot + 1'b1;
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: src/static_linked_list_engine.sv
// Top level of the static linked list engine: controller plus datapath.
// Depends on sll_pkg, sll_ctrl and sll_datapath.
//
//   Channel  Direction  Handshake        Beat
//   in_      input      valid / stall    sll_pkg::in_beat_t (func, position, value)
//   out_     output     valid / stall    sll_pkg::out_beat_t (status, element, last, length)
//
// An insert unlinks a fresh slot from the free list, walks the link RAM read port
// to the predecessor and splices the slot in. A traverse reads the list head and
// then gives one result per cycle while out_stall is low, one link and one data
// read per result. Reset clears the link valid bits at once; there is no sweep.
// A new beat is taken once the previous item is finished, even while its last
// result still waits in the output register under out_stall.
`timescale 1ns / 1ps
`default_nettype none

module static_linked_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sll_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sll_pkg::out_beat_t     out_data
);
  import sll_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sll_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

// File: src/sll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/sll_datapath.sv
// Datapath of the linked list engine: link and data RAMs, walk registers,
// element count and the output register. Depends on sll_pkg and sll_ram.
`timescale 1ns / 1ps
`default_nettype none

module sll_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sll_pkg::in_beat_t in_data,
  input  wire sll_pkg::cmd_t     cmd,
  output sll_pkg::stat_t         stat,
  output logic                   out_valid,
  output sll_pkg::out_beat_t     out_data,
  input  wire logic              out_stall
);
  import sll_pkg::*;

  logic                    func_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;
  logic [LEN_W-1:0]        count_r;
  logic [SLOT_W-1:0]       fresh_r;
  logic [SLOT_W-1:0]       k_r;
  logic [POS_W-1:0]        l_r;
  logic [LEN_W-1:0]        n_r;
  status_t                 resp_r;
  logic                    out_valid_r;
  out_beat_t               out_data_r;
  logic [SLOTS-1:0]        link_vld_r;
  logic                    rvld_r;
  logic [SLOT_W-1:0]       raddr_r;

  logic [SLOT_W-1:0] link_raddr;
  logic [SLOT_W-1:0] link_waddr;
  logic [SLOT_W-1:0] link_wdata;
  logic [SLOT_W-1:0] link_q;
  logic [SLOT_W-1:0] link_rdata;
  logic [VAL_W-1:0]  data_q;

  sll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (cmd.link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.link_re),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  sll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (cmd.data_we),
    .waddr (link_rdata),
    .wdata (val_r),
    .re    (cmd.data_re),
    .raddr (link_rdata),
    .rdata (data_q)
  );

  // A link entry that was never written reads as its reset chain value.
  assign link_rdata = rvld_r ? link_q : reset_link(raddr_r);

  always_comb begin
    unique case (cmd.link_ra)
      RA_FREE_HEAD: link_raddr = FREE_HEAD;
      RA_LIST_HEAD: link_raddr = HEAD_SLOT;
      RA_RDATA:     link_raddr = link_rdata;
      default:      link_raddr = FREE_HEAD;
    endcase
  end

  always_comb begin
    unique case (cmd.link_wa)
      WA_FREE_HEAD: link_waddr = FREE_HEAD;
      WA_FRESH:     link_waddr = fresh_r;
      WA_K:         link_waddr = k_r;
      default:      link_waddr = FREE_HEAD;
    endcase
  end

  assign link_wdata = (cmd.link_wd == WD_FRESH) ? fresh_r : link_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (cmd.link_we) begin
      link_vld_r[link_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link_re) begin
      rvld_r  <= link_vld_r[link_raddr];
      raddr_r <= link_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_data.func;
      pos_r  <= in_data.position;
      val_r  <= in_data.value;
    end
    if (cmd.fresh_ld) begin
      fresh_r <= link_rdata;
    end
    if (cmd.walk_init) begin
      k_r <= HEAD_SLOT;
      l_r <= POS_W'(1);
    end else if (cmd.walk_step) begin
      k_r <= link_rdata;
      l_r <= l_r + 1'b1;
    end
    if (cmd.trav_init) begin
      n_r <= '0;
    end else if (cmd.trav_step) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.resp_ld) begin
      resp_r <= cmd.resp_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_inc) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status  <= cmd.out_elem ? ST_OK : resp_r;
      out_data_r.element <= cmd.out_elem ? data_q : '0;
      out_data_r.last    <= cmd.out_elem ? stat.trav_last : 1'b1;
      out_data_r.length  <= count_r;
    end
  end

  always_comb begin
    stat.is_traverse = (func_r == FN_TRAVERSE);
    stat.pos_bad     = (pos_r == '0) ||
                       ((POS_W + 1)'(pos_r) > ((LEN_W + 1)'(count_r) + 1'b1));
    stat.count_zero  = (count_r == '0);
    stat.link_bad    = (link_rdata == '0) || ({1'b0, link_rdata} >= SLOT_LIMIT);
    stat.full        = (count_r >= COUNT_MAX) || (link_rdata == '0) ||
                       (link_rdata >= HEAD_SLOT);
    stat.walk_go     = (l_r < pos_r) && !stat.link_bad;
    stat.trav_last   = (((LEN_W + 1)'(n_r) + 1'b1) == (LEN_W + 1)'(count_r)) ||
                       stat.link_bad;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/sll_ctrl.sv
// Controller state machine of the linked list engine: sequences the insert
// walk and the traversal. Depends on sll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sll_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sll_pkg::stat_t stat,
  output sll_pkg::cmd_t       cmd
);
  import sll_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_traverse) begin
          state_nxt = stat.count_zero ? S_RESP : S_TRV_FIRST;
        end else begin
          state_nxt = stat.pos_bad ? S_RESP : S_INS_FRESH;
        end
      end
      S_INS_FRESH:  state_nxt = stat.full ? S_RESP : S_INS_UNLINK;
      S_INS_UNLINK: state_nxt = S_INS_WALK;
      S_INS_WALK: begin
        if (!stat.walk_go) begin
          state_nxt = S_INS_SPLICE;
        end
      end
      S_INS_SPLICE: state_nxt = S_RESP;
      S_TRV_FIRST:  state_nxt = stat.link_bad ? S_RESP : S_TRV_EMIT;
      S_TRV_EMIT: begin
        if (stat.out_free && stat.trav_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        if (stat.is_traverse) begin
          if (stat.count_zero) begin
            cmd.resp_ld   = 1'b1;
            cmd.resp_code = ST_EMPTY;
          end else begin
            cmd.link_re = 1'b1;
            cmd.link_ra = RA_LIST_HEAD;
          end
        end else if (stat.pos_bad) begin
          cmd.resp_ld   = 1'b1;
          cmd.resp_code = ST_RANGE;
        end else begin
          cmd.link_re = 1'b1;
          cmd.link_ra = RA_FREE_HEAD;
        end
      end
      S_INS_FRESH: begin
        if (stat.full) begin
          cmd.resp_ld   = 1'b1;
          cmd.resp_code = ST_FULL;
        end else begin
          cmd.fresh_ld = 1'b1;
          cmd.data_we  = 1'b1;
          cmd.link_re  = 1'b1;
          cmd.link_ra  = RA_RDATA;
        end
      end
      S_INS_UNLINK: begin
        cmd.link_we   = 1'b1;
        cmd.link_wa   = WA_FREE_HEAD;
        cmd.link_wd   = WD_RDATA;
        cmd.link_re   = 1'b1;
        cmd.link_ra   = RA_LIST_HEAD;
        cmd.walk_init = 1'b1;
      end
      S_INS_WALK: begin
        if (stat.walk_go) begin
          cmd.walk_step = 1'b1;
          cmd.link_re   = 1'b1;
          cmd.link_ra   = RA_RDATA;
        end else begin
          cmd.link_we = 1'b1;
          cmd.link_wa = WA_FRESH;
          cmd.link_wd = WD_RDATA;
        end
      end
      S_INS_SPLICE: begin
        cmd.link_we   = 1'b1;
        cmd.link_wa   = WA_K;
        cmd.link_wd   = WD_FRESH;
        cmd.count_inc = 1'b1;
        cmd.resp_ld   = 1'b1;
        cmd.resp_code = ST_OK;
      end
      S_TRV_FIRST: begin
        if (stat.link_bad) begin
          cmd.resp_ld   = 1'b1;
          cmd.resp_code = ST_EMPTY;
        end else begin
          cmd.link_re   = 1'b1;
          cmd.link_ra   = RA_RDATA;
          cmd.data_re   = 1'b1;
          cmd.trav_init = 1'b1;
        end
      end
      S_TRV_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_elem = 1'b1;
          if (!stat.trav_last) begin
            cmd.trav_step = 1'b1;
            cmd.link_re   = 1'b1;
            cmd.link_ra   = RA_RDATA;
            cmd.data_re   = 1'b1;
          end
        end
      end
      S_RESP: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/sll_checker.sv
// Port-level checker for the static linked list engine and its bind.
// Depends on sll_pkg and static_linked_list_engine.
`timescale 1ns / 1ps
`default_nettype none

module sll_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sll_pkg::out_beat_t out_data
);
  import sll_pkg::*;

  // A result held under stall keeps its beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // The engine works on one item at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // Every error or empty result closes its item and carries no element.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last && (out_data.element == '0))
    else $error("non-ok result without last or with an element");

  // The list never holds more than the data slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= COUNT_MAX)
    else $error("length beyond slot capacity");

  // An empty-list result can only report a zero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> out_data.length == '0)
    else $error("empty result with nonzero length");

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: verif/static_linked_list_engine_test.sv
// Self-checking testbench for the static linked list engine: directed and random
// inserts and traversals, checked beat by beat against an in-bench list predictor.
// Depends on sll_pkg and the static_linked_list_engine RTL.
`timescale 1ns / 1ps

module static_linked_list_engine_test;
  import sll_pkg::*;

  typedef struct {
    in_beat_t beat;
    bit       drain;
  } queued_op_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  logic [SLOT_W-1:0]       next_slot [SLOTS];
  logic signed [VAL_W-1:0] slot_value [SLOTS];
  int                      stored_count;

  out_beat_t  awaited_results[$];
  queued_op_t op_queue[$];
  int         mismatches;
  int         ops_accepted;
  int         gen_count;
  bit         beat_taken;
  bit         quiet;

  static_linked_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void push_result(status_t st, logic signed [VAL_W-1:0] el, logic lst,
                                      int len);
    out_beat_t r;
    r.status  = st;
    r.element = el;
    r.last    = lst;
    r.length  = LEN_W'(len);
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_list_op(in_beat_t b);
    int                pos;
    int                k;
    int                nx;
    int                cur;
    int                n;
    logic [SLOT_W-1:0] fresh;
    out_beat_t         tail;
    pos = int'(b.position);
    if (func_t'(b.func) == FN_INSERT) begin
      if (pos < 1 || pos > stored_count + 1) begin
        push_result(ST_RANGE, '0, 1'b1, stored_count);
      end else begin
        fresh = next_slot[FREE_HEAD];
        if (stored_count >= SLOTS - 2 || fresh == FREE_HEAD || fresh >= HEAD_SLOT) begin
          push_result(ST_FULL, '0, 1'b1, stored_count);
        end else begin
          next_slot[FREE_HEAD] = next_slot[fresh];
          slot_value[fresh] = b.value;
          k = int'(HEAD_SLOT);
          for (int l = 1; l < pos; l++) begin
            nx = int'(next_slot[k]);
            if (nx == 0) break;
            k = nx;
          end
          next_slot[fresh] = next_slot[k];
          next_slot[k] = fresh;
          stored_count++;
          push_result(ST_OK, '0, 1'b1, stored_count);
        end
      end
    end else begin
      n = 0;
      if (stored_count != 0) begin
        cur = int'(next_slot[HEAD_SLOT]);
        while (n < stored_count && cur != 0) begin
          push_result(ST_OK, slot_value[cur], 1'b0, stored_count);
          n++;
          cur = int'(next_slot[cur]);
        end
      end
      if (n == 0) begin
        push_result(ST_EMPTY, '0, 1'b1, stored_count);
      end else begin
        tail = awaited_results.pop_back();
        tail.last = 1'b1;
        awaited_results.push_back(tail);
      end
    end
  endfunction

  function automatic void add_op(func_t f, int pos, logic [VAL_W-1:0] val, bit drain);
    queued_op_t q;
    q.beat.func     = f;
    q.beat.position = POS_W'(pos);
    q.beat.value    = val;
    q.drain         = drain;
    op_queue.push_back(q);
    if (f == FN_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < SLOTS - 2) begin
      gen_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_list_op(in_data);
        beat_taken = 1'b1;
        ops_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected beat status=%0d element=%0d last=%0b length=%0d",
                     $realtime, out_data.status, out_data.element, out_data.last,
                     out_data.length);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status || out_data.element !== want.element ||
              out_data.last !== want.last || out_data.length !== want.length) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected status=%0d element=%0d last=%0b length=%0d",
                       $realtime, want.status, want.element, want.last, want.length);
              $display("%0t:          actual   status=%0d element=%0d last=%0b length=%0d",
                       $realtime, out_data.status, out_data.element, out_data.last,
                       out_data.length);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    quiet = ops_accepted >= 150 && ops_accepted < 250;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 28);
      if (!in_valid || beat_taken) begin
        beat_taken = 1'b0;
        if (op_queue.size() != 0 && !(op_queue[0].drain && awaited_results.size() != 0) &&
            (quiet || $urandom_range(0, 99) >= 28)) begin
          in_data <= op_queue[0].beat;
          in_valid <= 1'b1;
          void'(op_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int r;
    int p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    ops_accepted = 0;
    gen_count = 0;
    beat_taken = 1'b0;
    stored_count = 0;
    for (int s = 0; s < SLOTS; s++) begin
      next_slot[s] = (s == SLOTS - 1) ? '0 : SLOT_W'(s + 1);
      slot_value[s] = '0;
    end

    add_op(FN_TRAVERSE, 0, 32'h0, 1'b0);
    add_op(FN_INSERT, 0, 32'h1234_5678, 1'b0);
    add_op(FN_INSERT, 2, 32'h0000_0001, 1'b0);
    add_op(FN_INSERT, 63, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
    add_op(FN_INSERT, 2, 32'h8000_0000, 1'b0);
    add_op(FN_INSERT, 1, 32'h0000_0000, 1'b0);
    add_op(FN_INSERT, 2, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_TRAVERSE, 63, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_INSERT, 5, 32'h0000_0001, 1'b0);
    add_op(FN_INSERT, 7, 32'h5555_AAAA, 1'b0);
    add_op(FN_INSERT, 0, 32'hAAAA_5555, 1'b0);
    add_op(FN_INSERT, 3, 32'hDEAD_BEEF, 1'b0);
    add_op(FN_TRAVERSE, 0, 32'h0, 1'b0);

    for (int i = 0; i < 440; i++) begin
      r = $urandom_range(0, 99);
      if (gen_count < SLOTS - 2) begin
        if (r < 65) begin
          p = $urandom_range(1, gen_count + 1);
          add_op(FN_INSERT, p, $urandom, i == 0 || i == 200);
        end else if (r < 75) begin
          p = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(gen_count + 2, 63);
          add_op(FN_INSERT, p, $urandom, i == 0 || i == 200);
        end else begin
          add_op(FN_TRAVERSE, $urandom_range(0, 63), $urandom, i == 0 || i == 200);
        end
      end else if (r < 70) begin
        add_op(FN_INSERT, $urandom_range(0, 63), $urandom, i == 200);
      end else begin
        add_op(FN_TRAVERSE, $urandom_range(0, 63), $urandom, i == 200);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
